[rtl/qfr_pkg.sv]
// ----------------------------------------------------------------------------
// qfr_pkg
// Shared types and codes for the ordered record queue with keyed and
// first-fit removal.
// ----------------------------------------------------------------------------
package qfr_pkg;

  // Default number of records held
  localparam int QUEUE_DEPTH_DEF = 16;

  // Operation codes carried in the kind field
  localparam logic [1:0] KIND_APPEND  = 2'd0;
  localparam logic [1:0] KIND_RM_ID   = 2'd1;
  localparam logic [1:0] KIND_RM_FIT  = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_APPENDED = 2'd0;
  localparam logic [1:0] STAT_REJECTED = 2'd1;
  localparam logic [1:0] STAT_REMOVED  = 2'd2;
  localparam logic [1:0] STAT_NONE     = 2'd3;

  // One stored record
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] amount;
    logic [31:0] fee;
    logic [15:0] size;
  } rec_t;

endpackage

[rtl/qfr_if.sv]
// ----------------------------------------------------------------------------
// qfr_if
// Valid/ready channels for operation requests and their results.
// ----------------------------------------------------------------------------

// Operation request channel
interface qfr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] txn_id;
  logic [31:0] amount;
  logic [31:0] fee;
  logic [15:0] txn_size;
  logic [15:0] avail_size;

  modport source (
    output valid, kind, txn_id, amount, fee, txn_size, avail_size,
    input  ready
  );
  modport sink (
    input  valid, kind, txn_id, amount, fee, txn_size, avail_size,
    output ready
  );
endinterface

// Result channel
interface qfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] out_id;
  logic [31:0] out_amount;
  logic [31:0] out_fee;
  logic [15:0] out_size;

  modport source (
    output valid, status, out_id, out_amount, out_fee, out_size,
    input  ready
  );
  modport sink (
    input  valid, status, out_id, out_amount, out_fee, out_size,
    output ready
  );
endinterface

[rtl/qfr_store.sv]
// ----------------------------------------------------------------------------
// qfr_store
// Record memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module qfr_store #(
  parameter int DEPTH = qfr_pkg::QUEUE_DEPTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  qfr_pkg::rec_t  wdata,
  input  logic [AW-1:0]  raddr,
  output qfr_pkg::rec_t  rdata
);

  qfr_pkg::rec_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/qfr_match.sv]
// ----------------------------------------------------------------------------
// qfr_match
// Shared compare unit: checks one stored record against the search key,
// either an id match or a size that fits the available size.
// ----------------------------------------------------------------------------
module qfr_match (
  input  logic           by_id,
  input  logic [31:0]    key_id,
  input  logic [15:0]    key_avail,
  input  qfr_pkg::rec_t  rec,
  output logic           hit
);

  always_comb begin
    if (by_id) begin
      hit = (rec.id == key_id);
    end else begin
      hit = (rec.size <= key_avail);
    end
  end

endmodule

[rtl/ordered_queue_first_fit_removal_core.sv]
// ----------------------------------------------------------------------------
// ordered_queue_first_fit_removal_core
// Ordered record queue with append, remove-by-id and remove-oldest-fitting.
// A removal scans the records oldest first through one compare unit and,
// on a hit, closes the gap by moving each younger record up one place.
// ----------------------------------------------------------------------------
//   channel   dir  payload
//   req_in    in   kind, txn_id, amount, fee, txn_size, avail_size
//   rsp_out   out  status, out_id, out_amount, out_fee, out_size
//
// Append, rejection and an early "none found" go from the request straight
// to S_DONE and then to the result register. A removal makes one memory
// read per record in the scan and, when a record is taken out, one read
// and one write per record moved in the compaction.
// The request side is ready only when no request is in progress; a result
// waiting on rsp_out does not block a new request, only the next result.
// rst is synchronous and empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ordered_queue_first_fit_removal_core #(
  parameter int QUEUE_DEPTH = qfr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  qfr_in_if.sink           req_in,
  qfr_out_if.source        rsp_out
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [OW-1:0] DEPTH_W = OW'(QUEUE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_DONE} state_t;

  state_t           state;
  logic [OW-1:0]    occ;
  logic [OW-1:0]    cnt;
  logic [OW-1:0]    cnt_m1;
  logic [OW-1:0]    cnt_p1;
  logic             cvld;

  // Latched search key
  logic             op_by_id;
  logic [31:0]      op_id;
  logic [15:0]      op_avail;

  // Result being built, and the output register
  logic [1:0]       res_status;
  qfr_pkg::rec_t    res_rec;
  logic             out_valid;
  logic [1:0]       out_status;
  qfr_pkg::rec_t    out_rec;

  // Memory ports
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  qfr_pkg::rec_t    mem_wdata;
  qfr_pkg::rec_t    mem_rdata;
  qfr_pkg::rec_t    in_rec;
  logic             cmp_hit;
  logic             in_acc;
  logic             append_ok;

  assign in_rec.id     = req_in.txn_id;
  assign in_rec.amount = req_in.amount;
  assign in_rec.fee    = req_in.fee;
  assign in_rec.size   = req_in.txn_size;

  assign req_in.ready = (state == S_IDLE);
  assign in_acc       = req_in.valid && (state == S_IDLE);
  assign append_ok    = (req_in.txn_id != 32'd0) && (occ != DEPTH_W);
  assign cnt_m1       = OW'(cnt - OW'(1));
  assign cnt_p1       = OW'(cnt + OW'(1));

  // Read one place ahead while compacting so the record at cnt is on rdata
  assign mem_raddr = (state == S_SHIFT) ? cnt_p1[AW-1:0] : cnt[AW-1:0];

  // Memory write select: append at the tail, or move a record up one place
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = occ[AW-1:0];
    mem_wdata = in_rec;
    if (in_acc && (req_in.kind == qfr_pkg::KIND_APPEND) && append_ok) begin
      mem_we = 1'b1;
    end else if ((state == S_SHIFT) && (cnt < occ)) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_m1[AW-1:0];
      mem_wdata = mem_rdata;
    end
  end

  qfr_store #(
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  qfr_match u_match (
    .by_id     (op_by_id),
    .key_id    (op_id),
    .key_avail (op_avail),
    .rec       (mem_rdata),
    .hit       (cmp_hit)
  );

  // Sequencer: state, counters and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      cnt       <= '0;
      cvld      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Result taken; a new one loaded in S_DONE keeps valid high instead
      if (out_valid && rsp_out.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_in.valid) begin
            op_by_id <= (req_in.kind == qfr_pkg::KIND_RM_ID);
            op_id    <= req_in.txn_id;
            op_avail <= req_in.avail_size;
            res_rec  <= '0;
            cnt      <= '0;
            cvld     <= 1'b0;
            priority if (req_in.kind == qfr_pkg::KIND_APPEND) begin
              if (append_ok) begin
                occ        <= OW'(occ + OW'(1));
                res_status <= qfr_pkg::STAT_APPENDED;
              end else begin
                res_status <= qfr_pkg::STAT_REJECTED;
              end
              state <= S_DONE;
            end else if ((occ != '0) &&
                         ((req_in.kind == qfr_pkg::KIND_RM_FIT) ||
                          ((req_in.kind == qfr_pkg::KIND_RM_ID) &&
                           (req_in.txn_id != 32'd0)))) begin
              res_status <= qfr_pkg::STAT_NONE;
              state      <= S_SCAN;
            end else begin
              res_status <= qfr_pkg::STAT_NONE;
              state      <= S_DONE;
            end
          end
        end
        // Read data is registered and belongs to the address before cnt; a hit is at cnt - 1
        S_SCAN: begin
          if (cvld && cmp_hit) begin
            res_rec    <= mem_rdata;
            res_status <= qfr_pkg::STAT_REMOVED;
            state      <= S_SHIFT;
          end else if (cnt == occ) begin
            state <= S_DONE;
          end else begin
            cnt  <= OW'(cnt + OW'(1));
            cvld <= 1'b1;
          end
        end
        // Compaction: record at cnt moves to cnt - 1
        S_SHIFT: begin
          if (cnt < occ) begin
            cnt <= OW'(cnt + OW'(1));
          end else begin
            occ   <= cnt_m1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp_out.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_rec    <= res_rec;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_out.valid      = out_valid;
  assign rsp_out.status     = out_status;
  assign rsp_out.out_id     = out_rec.id;
  assign rsp_out.out_amount = out_rec.amount;
  assign rsp_out.out_fee    = out_rec.fee;
  assign rsp_out.out_size   = out_rec.size;

endmodule
